/* hw/rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Command and status types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int FIELD_W = 64;

	typedef enum logic [1:0] {
		ASEL_ONE,
		ASEL_Y,
		ASEL_Z
	} asel_t;

	typedef struct packed {
		logic  load;
		logic  mul_init;
		logic  mul_dbl;
		logic  mul_add;
		logic  mul_next;
		asel_t asel;
		logic  wr_y;
		logic  wr_z;
		logic  e_shift;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic e_zero;
		logic e_lsb;
		logic b_msb;
		logic cnt_zero;
	} status_t;

endpackage

/* hw/rtl/modular_exponentiation_unit.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base to the power exponent modulo a configured modulus.
// ----------------------------------------------------------------------------
// A request on the input channel carries base and exponent; each request
// gives one result, power, on the output channel. Both channels use valid
// and ready. The modulus is written through cfg_wr_en and cfg_wr_data; the
// user must do so only while the unit is idle, which the unit itself does
// not enforce. The modulus resets to one. The unit handles one request at
// a time. The base is first reduced by one modular product, then each
// exponent bit below the highest set bit costs a squaring and each set bit
// a multiply. A modular product runs in the shared shift-and-add multiplier
// as WIDTH doublings and up to WIDTH additions, one doubling or addition per
// cycle, followed by a write-back. With a 64-bit exponent the worst case is
// 128 products; a zero modulus skips all products and a zero exponent
// finishes after the base reduction alone.
// The result sits in an output register, so a stalled receiver does not
// block the next request from being accepted and computed; only the hand-off
// of that next result waits for the register to be taken. Reset clears the
// controller and the output valid.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
	parameter int WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mexp_pkg::FIELD_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mexp_pkg::FIELD_W-1:0] base,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mexp_pkg::FIELD_W-1:0] power
);
	import mexp_pkg::*;

	cmd_t    cmd;
	status_t sts;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.base        (base),
		.exponent    (exponent),
		.power       (power),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

/* hw/rtl/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the square-and-multiply loop and the bit-serial modular products.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mexp_pkg::status_t sts,
	output mexp_pkg::cmd_t    cmd
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DBL,
		S_ADD,
		S_FIN,
		S_LOOP,
		S_LOOPZ,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_RED,
		M_Y,
		M_Z
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   out_valid_q, out_valid_d;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		mode_d      = mode_q;
		case (mode_q)
			M_Y:     cmd.asel = ASEL_Y;
			M_Z:     cmd.asel = ASEL_Z;
			default: cmd.asel = ASEL_ONE;
		endcase
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (sts.m_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_init = 1'b1;
					mode_d       = M_RED;
					state_d      = S_DBL;
				end
			end
			S_DBL: begin
				cmd.mul_dbl = 1'b1;
				if (sts.b_msb) begin
					state_d = S_ADD;
				end else if (sts.cnt_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_next = 1'b1;
				end
			end
			S_ADD: begin
				cmd.mul_add = 1'b1;
				if (sts.cnt_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_next = 1'b1;
					state_d      = S_DBL;
				end
			end
			S_FIN: begin
				case (mode_q)
					M_Y: begin
						cmd.wr_y    = 1'b1;
						cmd.e_shift = 1'b1;
						state_d     = S_LOOPZ;
					end
					default: begin
						cmd.wr_z = 1'b1;
						state_d  = S_LOOP;
					end
				endcase
			end
			S_LOOP: begin
				if (sts.e_zero) begin
					state_d = S_DONE;
				end else if (sts.e_lsb) begin
					cmd.mul_init = 1'b1;
					mode_d       = M_Y;
					state_d      = S_DBL;
				end else begin
					cmd.e_shift = 1'b1;
					state_d     = S_LOOPZ;
				end
			end
			S_LOOPZ: begin
				if (sts.e_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_init = 1'b1;
					mode_d       = M_Z;
					state_d      = S_DBL;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_RED;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/mexp_dp.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus, operands, exponent and a shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
module mexp_dp #(
	parameter int WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mexp_pkg::FIELD_W-1:0]   cfg_wr_data,
	input  logic [mexp_pkg::FIELD_W-1:0]   base,
	input  logic [mexp_pkg::FIELD_W-1:0]   exponent,
	output logic [mexp_pkg::FIELD_W-1:0]   power,
	input  mexp_pkg::cmd_t                 cmd,
	output mexp_pkg::status_t              sts
);
	import mexp_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] z_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] bsh_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] power_q;
	logic [WIDTH-1:0] one;
	logic [WIDTH-1:0] a_op;
	logic [WIDTH-1:0] add_b;
	logic [WIDTH:0]   sum;
	logic [WIDTH+1:0] dif;
	logic [WIDTH-1:0] acc_sum;

	always_comb begin
		one = (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);
		case (cmd.asel)
			ASEL_Y:  a_op = y_q;
			ASEL_Z:  a_op = z_q;
			default: a_op = one;
		endcase
		add_b   = cmd.mul_add ? a_op : acc_q;
		sum     = {1'b0, acc_q} + {1'b0, add_b};
		dif     = {1'b0, sum} - {2'b00, m_q};
		acc_sum = dif[WIDTH+1] ? sum[WIDTH-1:0] : dif[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= WIDTH'(1);
		end else if (cfg_wr_en) begin
			m_q <= cfg_wr_data[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_q <= base[WIDTH-1:0];
			e_q <= exponent[WIDTH-1:0];
			y_q <= one;
		end else begin
			if (cmd.wr_y) begin
				y_q <= acc_q;
			end
			if (cmd.wr_z) begin
				z_q <= acc_q;
			end
			if (cmd.e_shift) begin
				e_q <= e_q >> 1;
			end
		end
		if (cmd.mul_init) begin
			acc_q <= '0;
			bsh_q <= z_q;
			cnt_q <= CW'(WIDTH - 1);
		end else begin
			if (cmd.mul_dbl || cmd.mul_add) begin
				acc_q <= acc_sum;
			end
			if (cmd.mul_next) begin
				bsh_q <= bsh_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
		end
		if (cmd.out_load) begin
			power_q <= (m_q == '0) ? '0 : y_q;
		end
	end

	assign sts.m_zero   = (m_q == '0);
	assign sts.e_zero   = (e_q == '0);
	assign sts.e_lsb    = e_q[0];
	assign sts.b_msb    = bsh_q[WIDTH-1];
	assign sts.cnt_zero = (cnt_q == '0);
	assign power        = FIELD_W'(power_q);

endmodule
